[src/bphist_pkg.sv]
// Shared constants, types and helper functions for the block pixel histogram unit.
// No dependencies; design files use scoped names, the checker and tb top import it.
package bphist_pkg;

   localparam int TOTAL_BLOCKS = 256;
   localparam int BINS         = 256;
   localparam int MAX_DIM      = 1024;

   localparam int CFG_W       = 11;
   localparam int ACROSS_W    = 9;
   localparam int PIX_W       = 8;
   localparam int IDX_W       = 8;
   localparam int BCOORD_W    = 8;
   localparam int BIN_W       = $clog2(BINS);
   localparam int BLK_W       = (TOTAL_BLOCKS > 1) ? $clog2(TOTAL_BLOCKS) : 1;
   localparam int STORE_DEPTH = TOTAL_BLOCKS * BINS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int POS_W       = $clog2(MAX_DIM);
   localparam int STEP_W      = ((POS_W > CFG_W) ? POS_W : CFG_W) + 1;
   localparam int PROD_W      = IDX_W + ACROSS_W;
   localparam int SUM_W       = PROD_W + 1;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam int RSP_DEPTH = 4;
   localparam int RPTR_W    = $clog2(RSP_DEPTH);
   localparam int RCNT_W    = $clog2(RSP_DEPTH + 1);

   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH      = 3'd0,
      CSR_IMAGE_HEIGHT     = 3'd1,
      CSR_COLUMN_STEP      = 3'd2,
      CSR_ROW_STEP         = 3'd3,
      CSR_BLOCKS_ACROSS    = 3'd4,
      CSR_BLOCKS_PER_IMAGE = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [CFG_W-1:0]    image_width;
      logic [CFG_W-1:0]    image_height;
      logic [CFG_W-1:0]    column_step;
      logic [CFG_W-1:0]    row_step;
      logic [ACROSS_W-1:0] blocks_across;
      logic [ACROSS_W-1:0] blocks_per_image;
   } cfg_type;

   typedef struct packed {
      logic              rd;
      logic              zero;
      logic [ADDR_W-1:0] addr;
   } op_type;

   function automatic logic [POS_W:0] dim_eff(input logic [CFG_W-1:0] v);
      logic [POS_W:0] r;
      if (v == '0) begin
         r = (POS_W + 1)'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = (POS_W + 1)'(MAX_DIM);
      end else begin
         r = (POS_W + 1)'(v);
      end
      return r;
   endfunction

   function automatic logic [CFG_W-1:0] step_eff(input logic [CFG_W-1:0] v);
      logic [CFG_W-1:0] r;
      if (v == '0) begin
         r = CFG_W'(1);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

[src/bphist_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bphist_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/bphist_front.sv]
// Front end: accepts request transactions, tracks frame position, forms store addresses.
// Depends on bphist_pkg.
module bphist_front (
   input  logic                               clock,
   input  logic                               reset,
   input  bphist_pkg::cfg_type                cfg,
   input  logic                               clr_busy,
   input  logic [bphist_pkg::QCNT_W-1:0]      q_count,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_action,
   input  logic [bphist_pkg::PIX_W-1:0]       req_pixel,
   input  logic [bphist_pkg::IDX_W-1:0]       req_image_index,
   input  logic [bphist_pkg::IDX_W-1:0]       req_block_index,
   input  logic [bphist_pkg::BIN_W-1:0]       req_bin,
   output logic                               q_push,
   output bphist_pkg::op_type                 q_op
);

   logic [bphist_pkg::POS_W-1:0]    pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [bphist_pkg::POS_W-1:0]    x_blk_ff, x_blk_in, y_blk_ff, y_blk_in;
   logic [bphist_pkg::BCOORD_W-1:0] col_ff, col_in, row_ff, row_in;

   logic                            s0_v_ff, s0_v_in;
   logic                            s0_rd_ff;
   logic                            s0_col_ok_ff;
   logic                            s0_idx_ok_ff;
   logic [bphist_pkg::PROD_W-1:0]   s0_prod_a_ff, s0_prod_b_ff;
   logic [bphist_pkg::BCOORD_W-1:0] s0_col_ff;
   logic [bphist_pkg::BIN_W-1:0]    s0_byte_ff;
   logic [bphist_pkg::IDX_W-1:0]    s0_idx_ff;

   logic                            accept, acc;
   logic [bphist_pkg::POS_W:0]      w_eff, h_eff;
   logic [bphist_pkg::CFG_W-1:0]    cstep, rstep;
   logic                            x_last, y_last, x_wrap, y_wrap;
   logic [bphist_pkg::SUM_W-1:0]    blk_sum;
   logic                            blk_ok;
   logic                            q_full;

   assign q_full = ({1'b0, q_count} + (bphist_pkg::QCNT_W + 1)'(s0_v_ff))
                   >= (bphist_pkg::QCNT_W + 1)'(bphist_pkg::QDEPTH);
   assign req_stall = clr_busy || q_full;
   assign accept = req_valid && !req_stall;
   assign acc = accept && !req_action;

   always_comb begin
      w_eff = bphist_pkg::dim_eff(cfg.image_width);
      h_eff = bphist_pkg::dim_eff(cfg.image_height);
      cstep = bphist_pkg::step_eff(cfg.column_step);
      rstep = bphist_pkg::step_eff(cfg.row_step);
      x_last = ({1'b0, pos_x_ff} + (bphist_pkg::POS_W + 1)'(1)) >= w_eff;
      y_last = ({1'b0, pos_y_ff} + (bphist_pkg::POS_W + 1)'(1)) >= h_eff;
      x_wrap = (bphist_pkg::STEP_W'(x_blk_ff) + bphist_pkg::STEP_W'(1))
               >= bphist_pkg::STEP_W'(cstep);
      y_wrap = (bphist_pkg::STEP_W'(y_blk_ff) + bphist_pkg::STEP_W'(1))
               >= bphist_pkg::STEP_W'(rstep);
   end

   // advance position on each accumulate
   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      x_blk_in = x_blk_ff;
      y_blk_in = y_blk_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      if (acc) begin
         if (x_last) begin
            pos_x_in = '0;
            x_blk_in = '0;
            col_in   = '0;
            if (y_last) begin
               pos_y_in = '0;
               y_blk_in = '0;
               row_in   = '0;
            end else begin
               pos_y_in = pos_y_ff + bphist_pkg::POS_W'(1);
               if (y_wrap) begin
                  y_blk_in = '0;
                  if (row_ff != '1) begin
                     row_in = row_ff + bphist_pkg::BCOORD_W'(1);
                  end
               end else begin
                  y_blk_in = y_blk_ff + bphist_pkg::POS_W'(1);
               end
            end
         end else begin
            pos_x_in = pos_x_ff + bphist_pkg::POS_W'(1);
            if (x_wrap) begin
               x_blk_in = '0;
               if (col_ff != '1) begin
                  col_in = col_ff + bphist_pkg::BCOORD_W'(1);
               end
            end else begin
               x_blk_in = x_blk_ff + bphist_pkg::POS_W'(1);
            end
         end
      end
   end

   assign s0_v_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         x_blk_ff <= '0;
         y_blk_ff <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         s0_v_ff  <= 1'b0;
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         x_blk_ff <= x_blk_in;
         y_blk_ff <= y_blk_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         s0_v_ff  <= s0_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_rd_ff     <= req_action;
         s0_prod_a_ff <= bphist_pkg::PROD_W'(req_image_index)
                         * bphist_pkg::PROD_W'(cfg.blocks_per_image);
         s0_prod_b_ff <= bphist_pkg::PROD_W'(row_ff)
                         * bphist_pkg::PROD_W'(cfg.blocks_across);
         s0_col_ff    <= col_ff;
         s0_col_ok_ff <= {1'b0, col_ff} < cfg.blocks_across;
         s0_byte_ff   <= req_action ? req_bin : req_pixel;
         s0_idx_ff    <= req_block_index;
         s0_idx_ok_ff <= int'(req_block_index) < bphist_pkg::TOTAL_BLOCKS;
      end
   end

   always_comb begin
      blk_sum = bphist_pkg::SUM_W'(s0_prod_a_ff) + bphist_pkg::SUM_W'(s0_prod_b_ff)
                + bphist_pkg::SUM_W'(s0_col_ff);
      blk_ok  = int'(blk_sum) < bphist_pkg::TOTAL_BLOCKS;
      q_op.rd   = s0_rd_ff;
      q_op.zero = s0_rd_ff && !s0_idx_ok_ff;
      if (s0_rd_ff) begin
         q_op.addr = bphist_pkg::ADDR_W'({bphist_pkg::BLK_W'(s0_idx_ff), s0_byte_ff});
      end else begin
         q_op.addr = bphist_pkg::ADDR_W'({bphist_pkg::BLK_W'(blk_sum), s0_byte_ff});
      end
      q_push = s0_v_ff && (s0_rd_ff || (s0_col_ok_ff && blk_ok));
   end

endmodule

[src/bphist_queue.sv]
// Short operation queue between front end and back end.
// Depends on bphist_pkg.
module bphist_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  bphist_pkg::op_type            push_op,
   input  logic                          pop,
   output bphist_pkg::op_type            head,
   output logic                          empty,
   output logic [bphist_pkg::QCNT_W-1:0] count
);

   bphist_pkg::op_type                mem_ff [bphist_pkg::QDEPTH];
   logic [bphist_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [bphist_pkg::QCNT_W-1:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == bphist_pkg::QPTR_W'(bphist_pkg::QDEPTH - 1))
                     ? '0 : wr_ptr_ff + bphist_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == bphist_pkg::QPTR_W'(bphist_pkg::QDEPTH - 1))
                     ? '0 : rd_ptr_ff + bphist_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + bphist_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - bphist_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

endmodule

[src/bphist_back.sv]
// Back end: clearing pass, counter read-modify-write with forwarding, response buffer.
// Depends on bphist_pkg and bphist_ram.
module bphist_back (
   input  logic                         clock,
   input  logic                         reset,
   input  bphist_pkg::op_type           q_head,
   input  logic                         q_empty,
   output logic                         q_pop,
   output logic                         clr_busy,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [bphist_pkg::PIX_W-1:0] rsp_count
);

   logic                              clr_busy_ff, clr_busy_in;
   logic [bphist_pkg::ADDR_W-1:0]     clr_addr_ff, clr_addr_in;
   logic                              e2_v_ff;
   bphist_pkg::op_type                e2_op_ff;
   logic                              fwd_v_ff, fwd_v_in;
   logic [bphist_pkg::ADDR_W-1:0]     fwd_addr_ff;
   logic [bphist_pkg::PIX_W-1:0]      fwd_data_ff;

   logic [bphist_pkg::PIX_W-1:0]      rsp_mem_ff [bphist_pkg::RSP_DEPTH];
   logic [bphist_pkg::RPTR_W-1:0]     rsp_wr_ff, rsp_wr_in, rsp_rd_ff, rsp_rd_in;
   logic [bphist_pkg::RCNT_W-1:0]     rsp_cnt_ff, rsp_cnt_in;

   logic                              e2_rd, e2_acc, credit_ok;
   logic                              ram_we;
   logic [bphist_pkg::ADDR_W-1:0]     ram_wr_addr;
   logic [bphist_pkg::PIX_W-1:0]      ram_wr_data, ram_rd_data, cur, inc;
   logic                              rsp_push, rsp_pop;
   logic [bphist_pkg::PIX_W-1:0]      rsp_data;

   assign e2_rd  = e2_v_ff && e2_op_ff.rd;
   assign e2_acc = e2_v_ff && !e2_op_ff.rd;
   assign credit_ok = ({1'b0, rsp_cnt_ff} + (bphist_pkg::RCNT_W + 1)'(e2_rd))
                      < (bphist_pkg::RCNT_W + 1)'(bphist_pkg::RSP_DEPTH);
   assign q_pop = !clr_busy_ff && !q_empty && (!q_head.rd || credit_ok);
   assign clr_busy = clr_busy_ff;

   // take the value written last cycle, the RAM read missed it
   assign cur = (fwd_v_ff && (fwd_addr_ff == e2_op_ff.addr)) ? fwd_data_ff : ram_rd_data;
   assign inc = cur + bphist_pkg::PIX_W'(1);

   always_comb begin
      ram_we      = clr_busy_ff || e2_acc;
      ram_wr_addr = clr_busy_ff ? clr_addr_ff : e2_op_ff.addr;
      ram_wr_data = clr_busy_ff ? '0 : inc;
      fwd_v_in    = e2_acc;
   end

   bphist_ram #(
      .WIDTH (bphist_pkg::PIX_W),
      .DEPTH (bphist_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (q_head.addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         if (clr_addr_ff == bphist_pkg::ADDR_W'(bphist_pkg::STORE_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + bphist_pkg::ADDR_W'(1);
         end
      end
   end

   assign rsp_push = e2_rd;
   assign rsp_data = e2_op_ff.zero ? '0 : cur;
   assign rsp_valid = (rsp_cnt_ff != '0);
   assign rsp_pop = rsp_valid && !rsp_stall;
   assign rsp_count = rsp_mem_ff[rsp_rd_ff];

   always_comb begin
      rsp_wr_in  = rsp_wr_ff;
      rsp_rd_in  = rsp_rd_ff;
      rsp_cnt_in = rsp_cnt_ff;
      if (rsp_push) begin
         rsp_wr_in = (rsp_wr_ff == bphist_pkg::RPTR_W'(bphist_pkg::RSP_DEPTH - 1))
                     ? '0 : rsp_wr_ff + bphist_pkg::RPTR_W'(1);
      end
      if (rsp_pop) begin
         rsp_rd_in = (rsp_rd_ff == bphist_pkg::RPTR_W'(bphist_pkg::RSP_DEPTH - 1))
                     ? '0 : rsp_rd_ff + bphist_pkg::RPTR_W'(1);
      end
      if (rsp_push && !rsp_pop) begin
         rsp_cnt_in = rsp_cnt_ff + bphist_pkg::RCNT_W'(1);
      end else if (rsp_pop && !rsp_push) begin
         rsp_cnt_in = rsp_cnt_ff - bphist_pkg::RCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         e2_v_ff     <= 1'b0;
         fwd_v_ff    <= 1'b0;
         rsp_wr_ff   <= '0;
         rsp_rd_ff   <= '0;
         rsp_cnt_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
         e2_v_ff     <= q_pop;
         fwd_v_ff    <= fwd_v_in;
         rsp_wr_ff   <= rsp_wr_in;
         rsp_rd_ff   <= rsp_rd_in;
         rsp_cnt_ff  <= rsp_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      e2_op_ff    <= q_head;
      fwd_addr_ff <= e2_op_ff.addr;
      fwd_data_ff <= inc;
      if (rsp_push) begin
         rsp_mem_ff[rsp_wr_ff] <= rsp_data;
      end
   end

endmodule

[src/block_pixel_histogram_unit.sv]
// Block pixel histogram unit: top level with configuration registers.
// Throughput one transaction per cycle while req_stall is low; a read passes the front-end
// register, queue, back-end register and response buffer. Rate is set by the counter store,
// with one read port and one write port per cycle, and the last write forwarded into the
// read-modify-write. Reset: synchronous; a clearing pass then zeroes all TOTAL_BLOCKS*BINS
// counters, during which req_stall is high. Depends on bphist_pkg and submodules.
module block_pixel_histogram_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [bphist_pkg::PIX_W-1:0]        req_pixel,
   input  logic [bphist_pkg::IDX_W-1:0]        req_image_index,
   input  logic [bphist_pkg::IDX_W-1:0]        req_block_index,
   input  logic [bphist_pkg::BIN_W-1:0]        req_bin,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bphist_pkg::PIX_W-1:0]        rsp_count,
   input  logic                                csr_write,
   input  logic [bphist_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bphist_pkg::CFG_W-1:0]        csr_data
);

   bphist_pkg::cfg_type               cfg_ff, cfg_in;
   logic                              clr_busy;
   logic                              q_push, q_pop, q_empty;
   bphist_pkg::op_type                q_op, q_head;
   logic [bphist_pkg::QCNT_W-1:0]     q_count;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            bphist_pkg::CSR_IMAGE_WIDTH:      cfg_in.image_width  = csr_data;
            bphist_pkg::CSR_IMAGE_HEIGHT:     cfg_in.image_height = csr_data;
            bphist_pkg::CSR_COLUMN_STEP:      cfg_in.column_step  = csr_data;
            bphist_pkg::CSR_ROW_STEP:         cfg_in.row_step     = csr_data;
            bphist_pkg::CSR_BLOCKS_ACROSS:
               cfg_in.blocks_across = bphist_pkg::ACROSS_W'(csr_data);
            bphist_pkg::CSR_BLOCKS_PER_IMAGE:
               cfg_in.blocks_per_image = bphist_pkg::ACROSS_W'(csr_data);
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width      <= bphist_pkg::CFG_W'(64);
         cfg_ff.image_height     <= bphist_pkg::CFG_W'(64);
         cfg_ff.column_step      <= bphist_pkg::CFG_W'(8);
         cfg_ff.row_step         <= bphist_pkg::CFG_W'(8);
         cfg_ff.blocks_across    <= bphist_pkg::ACROSS_W'(8);
         cfg_ff.blocks_per_image <= bphist_pkg::ACROSS_W'(64);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bphist_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .clr_busy        (clr_busy),
      .q_count         (q_count),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_pixel       (req_pixel),
      .req_image_index (req_image_index),
      .req_block_index (req_block_index),
      .req_bin         (req_bin),
      .q_push          (q_push),
      .q_op            (q_op)
   );

   bphist_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (q_op),
      .pop     (q_pop),
      .head    (q_head),
      .empty   (q_empty),
      .count   (q_count)
   );

   bphist_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .clr_busy  (clr_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_count (rsp_count)
   );

endmodule

[tb/bphist_tb_pkg.sv]
`timescale 1ns / 100ps
// Action codes shared by the histogram testbench top and its checker.
// No dependencies.
package bphist_tb_pkg;

   typedef enum logic {
      ACT_ACCUMULATE = 1'b0,
      ACT_READ       = 1'b1
   } action_type;

endpackage

[tb/bphist_checker.sv]
`timescale 1ns / 100ps
// Checker for the block pixel histogram unit: follows raster position and the per-block
// bin counters from accepted transactions and compares every returned count.
// Depends on bphist_pkg and bphist_tb_pkg.
module bphist_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic                             req_action,
   input  logic [bphist_pkg::PIX_W-1:0]     req_pixel,
   input  logic [bphist_pkg::IDX_W-1:0]     req_image_index,
   input  logic [bphist_pkg::IDX_W-1:0]     req_block_index,
   input  logic [bphist_pkg::BIN_W-1:0]     req_bin,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [bphist_pkg::PIX_W-1:0]     rsp_count,
   input  logic                             csr_write,
   input  logic [bphist_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bphist_pkg::CFG_W-1:0]     csr_data,
   output int unsigned                      mismatches,
   output int unsigned                      counts_pending
);
   import bphist_pkg::*;
   import bphist_tb_pkg::*;

   logic [PIX_W-1:0]    counters [STORE_DEPTH];
   cfg_type             cfg;
   logic [POS_W-1:0]    col, row, col_in_block, row_in_block;
   logic [BCOORD_W-1:0] block_col, block_row;
   logic [PIX_W-1:0]    expected_counts [$];
   logic [PIX_W-1:0]    due_count;

   function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
      int unsigned d;
      d = v;
      if (d == 0) begin
         d = 1;
      end else if (d > MAX_DIM) begin
         d = MAX_DIM;
      end
      return d;
   endfunction

   task automatic report(input string msg);
      if (mismatches < 100) begin
         $display("%0t ERROR %s", $realtime, msg);
      end
      mismatches++;
   endtask

   task automatic accumulate(input logic [PIX_W-1:0] value, input logic [IDX_W-1:0] slot);
      int unsigned w, h, cstep, rstep, blk, addr;
      w = clamp_dim(cfg.image_width);
      h = clamp_dim(cfg.image_height);
      cstep = (cfg.column_step == '0) ? 1 : int'(cfg.column_step);
      rstep = (cfg.row_step == '0) ? 1 : int'(cfg.row_step);
      if (block_col < cfg.blocks_across) begin
         blk = int'(slot) * int'(cfg.blocks_per_image)
             + int'(block_row) * int'(cfg.blocks_across) + int'(block_col);
         if (blk < TOTAL_BLOCKS) begin
            addr = blk * BINS + int'(value);
            counters[addr] = counters[addr] + 1'b1;
         end
      end
      // advance raster position
      if (col + 1 >= w) begin
         col = '0;
         col_in_block = '0;
         block_col = '0;
         if (row + 1 >= h) begin
            row = '0;
            row_in_block = '0;
            block_row = '0;
         end else begin
            row = row + 1'b1;
            if (row_in_block + 1 >= rstep) begin
               row_in_block = '0;
               if (block_row != '1) block_row = block_row + 1'b1;
            end else begin
               row_in_block = row_in_block + 1'b1;
            end
         end
      end else begin
         col = col + 1'b1;
         if (col_in_block + 1 >= cstep) begin
            col_in_block = '0;
            if (block_col != '1) block_col = block_col + 1'b1;
         end else begin
            col_in_block = col_in_block + 1'b1;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) counters[i] = '0;
         cfg = '{image_width: CFG_W'(64), image_height: CFG_W'(64),
                 column_step: CFG_W'(8), row_step: CFG_W'(8),
                 blocks_across: ACROSS_W'(8), blocks_per_image: ACROSS_W'(64)};
         col = '0;
         row = '0;
         col_in_block = '0;
         row_in_block = '0;
         block_col = '0;
         block_row = '0;
         expected_counts.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_counts.size() == 0) begin
               report($sformatf("count %0d returned with no read outstanding", rsp_count));
            end else begin
               due_count = expected_counts.pop_front();
               if (rsp_count !== due_count) begin
                  report($sformatf("count: expected %0d, got %0d", due_count, rsp_count));
               end
            end
         end
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_IMAGE_WIDTH:      cfg.image_width = csr_data;
               CSR_IMAGE_HEIGHT:     cfg.image_height = csr_data;
               CSR_COLUMN_STEP:      cfg.column_step = csr_data;
               CSR_ROW_STEP:         cfg.row_step = csr_data;
               CSR_BLOCKS_ACROSS:    cfg.blocks_across = csr_data[ACROSS_W-1:0];
               CSR_BLOCKS_PER_IMAGE: cfg.blocks_per_image = csr_data[ACROSS_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_action == ACT_READ) begin
               expected_counts.push_back((int'(req_block_index) < TOTAL_BLOCKS)
                  ? counters[int'(req_block_index) * BINS + int'(req_bin)] : '0);
            end else begin
               accumulate(req_pixel, req_image_index);
            end
         end
      end
      counts_pending <= expected_counts.size();
   end

endmodule

[tb/tb_block_pixel_histogram_unit.sv]
`timescale 1ns / 100ps
// Testbench top for block_pixel_histogram_unit: clock, reset, register writes, request
// and response traffic with random idling, and the verdict.
// Depends on bphist_pkg, bphist_tb_pkg and bphist_checker.
module tb_block_pixel_histogram_unit;
   import bphist_pkg::*;
   import bphist_tb_pkg::*;

   localparam int unsigned RUN_LIMIT   = 800000;
   localparam int unsigned HOLD_CYCLES = 120;
   localparam int unsigned SETTLE      = 12;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_action = ACT_ACCUMULATE;
   logic [PIX_W-1:0]     req_pixel = '0;
   logic [IDX_W-1:0]     req_image_index = '0;
   logic [IDX_W-1:0]     req_block_index = '0;
   logic [BIN_W-1:0]     req_bin = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [PIX_W-1:0]     rsp_count;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_data = '0;
   int unsigned          mismatches;
   int unsigned          counts_pending;

   bit          long_hold = 1'b0;
   bit          calm = 1'b0;
   int unsigned pixels_sent = 0;
   int unsigned reads_sent = 0;
   int unsigned phases_run = 0;

   block_pixel_histogram_unit uut (.*);
   bphist_checker u_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin : watchdog
      repeat (RUN_LIMIT) @(posedge clock);
      $display("block_pixel_histogram_unit verification failed");
      $finish;
   end

   initial begin : rsp_side
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold = 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic offer(input action_type act, input logic [PIX_W-1:0] pix,
                        input logic [IDX_W-1:0] img, input logic [IDX_W-1:0] blk,
                        input logic [BIN_W-1:0] bn);
      req_valid <= 1'b1;
      req_action <= act;
      req_pixel <= pix;
      req_image_index <= img;
      req_block_index <= blk;
      req_bin <= bn;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (act == ACT_READ) begin
         reads_sent++;
      end else begin
         pixels_sent++;
      end
   endtask

   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic [IDX_W-1:0] img);
      offer(ACT_ACCUMULATE, pix, img, IDX_W'($urandom), BIN_W'($urandom));
   endtask

   task automatic send_read(input logic [IDX_W-1:0] blk, input logic [BIN_W-1:0] bn);
      offer(ACT_READ, PIX_W'($urandom), IDX_W'($urandom), blk, bn);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (counts_pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int unsigned value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= CFG_W'(value);
      @(posedge clock);
   endtask

   task automatic apply_config(input int unsigned w, h, cs, rs, ba, bpi);
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      write_reg(CSR_COLUMN_STEP, cs);
      write_reg(CSR_ROW_STEP, rs);
      write_reg(CSR_BLOCKS_ACROSS, ba);
      write_reg(CSR_BLOCKS_PER_IMAGE, bpi);
      csr_write <= 1'b0;
   endtask

   task automatic run_phase(input int unsigned w, h, cs, rs, ba, bpi, slot, items,
                            read_pct, palette, hold_at, pause_at);
      int unsigned rows, rstep, span, base, target, hue;
      apply_config(w, h, cs, rs, ba, bpi);
      hue = $urandom_range(0, 255);
      base = slot * bpi;
      rstep = (rs == 0) ? 1 : rs;
      rows = (h == 0) ? 1 : ((h > MAX_DIM) ? MAX_DIM : h);
      rows = (rows + rstep - 1) / rstep;
      span = (ba * rows > TOTAL_BLOCKS) ? TOTAL_BLOCKS : ba * rows;
      for (int unsigned i = 1; i <= items; i++) begin
         if (i == hold_at) long_hold = 1'b1;
         if (i == pause_at) drain();
         if (!calm && $urandom_range(0, 7) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         if ($urandom_range(0, 99) < read_pct) begin
            target = base + $urandom_range(0, span - 1);
            if (target >= TOTAL_BLOCKS || $urandom_range(0, 9) == 0) begin
               target = $urandom_range(0, 255);
            end
            send_read(IDX_W'(target), ($urandom_range(0, 4) != 0)
                      ? BIN_W'(hue + $urandom_range(0, palette - 1)) : BIN_W'($urandom));
         end else begin
            send_pixel(($urandom_range(0, 6) != 0)
                       ? PIX_W'(hue + $urandom_range(0, palette - 1)) : PIX_W'($urandom),
                       ($urandom_range(0, 9) != 0) ? IDX_W'(slot) : IDX_W'($urandom));
         end
      end
      drain();
      phases_run++;
   endtask

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: extremes of every field, dropped slot, back-to-back hits
      send_pixel(8'h00, 8'd0);
      send_pixel(8'hFF, 8'd0);
      send_pixel(8'hFF, 8'd0);
      send_pixel(8'h5A, 8'd3);
      send_pixel(8'hA5, 8'd255);
      send_pixel(8'hFF, 8'd1);
      send_read(8'd0, 8'h00);
      send_read(8'd0, 8'hFF);
      send_read(8'd192, 8'h5A);
      send_read(8'd0, 8'hA5);
      send_read(8'd64, 8'hFF);
      send_read(8'd255, 8'hFF);
      send_read(8'd255, 8'h00);
      send_pixel(8'h07, 8'd0);
      send_read(8'd0, 8'h07);
      send_pixel(8'h07, 8'd0);
      send_pixel(8'h07, 8'd0);
      send_read(8'd0, 8'h07);
      send_read(8'd1, 8'h07);
      send_pixel(8'h07, 8'd0);
      send_read(8'd1, 8'h07);
      drain();

      run_phase(6, 5, 2, 2, 3, 9, 1, 150, 25, 4, 60, 0);
      run_phase(7, 3, 3, 2, 2, 6, 2, 150, 25, 4, 0, 75);
      run_phase(0, 0, 0, 0, 1, 1, 5, 400, 10, 1, 0, 0);
      run_phase(300, 2, 1, 1, 256, 256, 0, 350, 15, 8, 0, 0);
      run_phase(1024, 1024, 1024, 1024, 1, 256, 0, 150, 20, 4, 0, 0);
      run_phase(2047, 2047, 2047, 2047, 256, 1, 7, 80, 20, 4, 0, 0);
      calm = 1'b1;
      run_phase(9, 4, 4, 3, 3, 10, 3, 180, 25, 6, 0, 0);

      $display("Run covered %0d pixels and %0d bin reads over %0d geometries plus reset",
               pixels_sent, reads_sent, phases_run);
      $display("  including clipped and dropped blocks, saturated columns and counter wrap");
      if (mismatches == 0) begin
         $display("block_pixel_histogram_unit verification clean");
      end else begin
         $display("block_pixel_histogram_unit verification failed");
      end
      $finish;
   end

endmodule
